// File: rtl/utt_pkg.sv
// Shared types, constants and decode functions of the UTF-8 to UTF-16 transcoder.
package utt_pkg;

  localparam int UTT_QDEPTH = 4;

  localparam logic [31:0] CP_PLANE1  = 32'h0001_0000;
  localparam logic [31:0] CP_LIMIT   = 32'h0011_0000;
  localparam logic [20:0] PAIR_BASE  = 21'h01_0000;
  localparam logic [15:0] HI_BASE    = 16'hD800;
  localparam logic [15:0] LO_BASE    = 16'hDC00;
  localparam logic [15:0] UNIT_REPL  = 16'hFFFD;

  typedef enum logic [1:0] {
    KIND_UNIT   = 2'd0,
    KIND_TERM   = 2'd1,
    KIND_CUT    = 2'd2,
    KIND_NOTERM = 2'd3
  } utt_kind_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } utt_in_t;

  typedef struct packed {
    utt_kind_t   kind;
    logic [15:0] code_unit;
    logic [2:0]  missing_extra;
    logic        final_result;
  } utt_out_t;

  // One queued command: a finished sequence or a sequence cut by the buffer end.
  typedef struct packed {
    logic        cut;
    logic        last;
    logic [2:0]  extra;
    logic [31:0] acc;
  } utt_cmd_t;

  function automatic logic [2:0] lead_extra(input logic [7:0] b);
    logic [2:0] n;
    if (b < 8'hC0) begin
      n = 3'd0;
    end else if (b < 8'hE0) begin
      n = 3'd1;
    end else if (b < 8'hF0) begin
      n = 3'd2;
    end else if (b < 8'hF8) begin
      n = 3'd3;
    end else if (b < 8'hFC) begin
      n = 3'd4;
    end else begin
      n = 3'd5;
    end
    return n;
  endfunction

  function automatic logic [31:0] seq_offset(input logic [2:0] extra);
    logic [31:0] off;
    case (extra)
      3'd1: off = 32'h0000_3080;
      3'd2: off = 32'h000E_2080;
      3'd3: off = 32'h03C8_2080;
      3'd4: off = 32'hFA08_2080;
      3'd5: off = 32'h8208_2080;
      default: off = 32'h0000_0000;
    endcase
    return off;
  endfunction

endpackage

// File: rtl/utt_front.sv
// Front end: folds source bytes into sequences and issues commands to the queue.
module utt_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  utt_pkg::utt_in_t   in_item,
  output logic               cmd_valid,
  output utt_pkg::utt_cmd_t  cmd
);
  import utt_pkg::*;

  logic [31:0] acc_r, acc_nxt;
  logic [2:0]  bytes_left_r, bytes_left_nxt;
  logic [2:0]  extra_r, extra_nxt;
  logic        discarding_r, discarding_nxt;

  logic        left_zero;
  logic [31:0] fold;
  logic [2:0]  extra_cur;
  logic [2:0]  left_dec;
  logic        done;
  logic        is_term;

  always_comb begin
    left_zero = (bytes_left_r == 3'd0);
    fold      = left_zero ? {24'd0, in_item.in_byte}
                          : {acc_r[25:0], 6'd0} + {24'd0, in_item.in_byte};
    extra_cur = left_zero ? lead_extra(in_item.in_byte) : extra_r;
    left_dec  = left_zero ? lead_extra(in_item.in_byte) : bytes_left_r - 3'd1;
    done      = (left_dec == 3'd0);
    is_term   = (fold == seq_offset(extra_cur));

    acc_nxt        = acc_r;
    bytes_left_nxt = bytes_left_r;
    extra_nxt      = extra_r;
    discarding_nxt = discarding_r;
    cmd_valid      = 1'b0;
    cmd.cut        = !done;
    cmd.last       = in_item.last_byte;
    cmd.extra      = extra_cur;
    cmd.acc        = fold;

    if (accept) begin
      if (discarding_r) begin
        if (in_item.last_byte) begin
          discarding_nxt = 1'b0;
        end
      end else begin
        acc_nxt   = fold;
        extra_nxt = extra_cur;
        if (done) begin
          cmd_valid      = 1'b1;
          bytes_left_nxt = 3'd0;
          // A terminator that is not on the last byte drops the rest of the buffer.
          discarding_nxt = is_term && !in_item.last_byte;
        end else if (in_item.last_byte) begin
          cmd_valid      = 1'b1;
          bytes_left_nxt = 3'd0;
        end else begin
          bytes_left_nxt = left_dec;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r        <= '0;
      bytes_left_r <= '0;
      extra_r      <= '0;
      discarding_r <= 1'b0;
    end else begin
      acc_r        <= acc_nxt;
      bytes_left_r <= bytes_left_nxt;
      extra_r      <= extra_nxt;
      discarding_r <= discarding_nxt;
    end
  end

  a_discard_idle: assert property (@(posedge clk) disable iff (!rst_n)
    discarding_r |-> (bytes_left_r == 3'd0))
    else $error("discarding while a sequence is open");

endmodule

// File: rtl/utt_queue.sv
// Short command queue between the front end and the back end.
module utt_queue #(
  parameter int DEPTH = utt_pkg::UTT_QDEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  utt_pkg::utt_cmd_t  wr_data,
  output logic               full,
  output logic               rd_valid,
  input  logic               rd_en,
  output utt_pkg::utt_cmd_t  rd_data
);
  import utt_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  utt_cmd_t         mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_wr, do_rd;

  always_comb begin
    full     = (count_r == CNT_FULL);
    rd_valid = (count_r != '0);
    rd_data  = mem_r[rd_ptr_r];
    do_wr    = wr_en && !full;
    do_rd    = rd_en && rd_valid;

    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("queue count beyond depth");

endmodule

// File: rtl/utt_back.sv
// Back end: turns queued commands into UTF-16 results, one result per cycle while the receiver pops.
module utt_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  utt_pkg::utt_cmd_t  q_data,
  output logic               q_pop,
  output logic               empty,
  input  logic               pop,
  output utt_pkg::utt_out_t  out_data
);
  import utt_pkg::*;

  // Decode stage: holds the code point of the command being expanded.
  logic        d_valid_r, d_valid_nxt;
  logic [31:0] d_cp_r, d_cp_nxt;
  logic        d_last_r, d_last_nxt;
  logic        d_cut_r, d_cut_nxt;
  logic [2:0]  d_miss_r, d_miss_nxt;
  logic [1:0]  idx_r, idx_nxt;

  logic        out_valid_r, out_valid_nxt;
  utt_out_t    out_r, out_nxt;

  logic        is_zero, is_bmp, is_pair;
  logic [20:0] pair_v;
  logic [1:0]  n_units, n_res;
  utt_out_t    res;
  logic        o_load, emit, d_done;

  always_comb begin
    is_zero = (d_cp_r == 32'd0);
    is_bmp  = (d_cp_r < CP_PLANE1);
    is_pair = !is_bmp && (d_cp_r < CP_LIMIT);
    pair_v  = d_cp_r[20:0] - PAIR_BASE;
    n_units = is_pair ? 2'd2 : 2'd1;
    if (d_cut_r || is_zero) begin
      n_res = 2'd1;
    end else begin
      n_res = n_units + {1'b0, d_last_r};
    end

    res.kind          = KIND_UNIT;
    res.code_unit     = 16'd0;
    res.missing_extra = 3'd0;
    res.final_result  = (idx_r == n_res - 2'd1);
    if (d_cut_r) begin
      res.kind          = KIND_CUT;
      res.missing_extra = d_miss_r;
    end else if (is_zero) begin
      res.kind = KIND_TERM;
    end else if (idx_r < n_units) begin
      if (is_bmp) begin
        res.code_unit = d_cp_r[15:0];
      end else if (is_pair) begin
        res.code_unit = (idx_r == 2'd0) ? (HI_BASE | {6'd0, pair_v[19:10]})
                                        : (LO_BASE | {6'd0, pair_v[9:0]});
      end else begin
        res.code_unit = UNIT_REPL;
      end
    end else begin
      res.kind = KIND_NOTERM;
    end

    o_load = !out_valid_r || pop;
    emit   = d_valid_r && o_load;
    d_done = emit && res.final_result;
    q_pop  = q_valid && (!d_valid_r || d_done);

    idx_nxt = idx_r;
    if (emit) begin
      idx_nxt = res.final_result ? 2'd0 : idx_r + 2'd1;
    end

    d_valid_nxt = d_valid_r;
    d_cp_nxt    = d_cp_r;
    d_last_nxt  = d_last_r;
    d_cut_nxt   = d_cut_r;
    d_miss_nxt  = d_miss_r;
    if (q_pop) begin
      d_valid_nxt = 1'b1;
      d_cp_nxt    = q_data.acc - seq_offset(q_data.extra);
      d_last_nxt  = q_data.last;
      d_cut_nxt   = q_data.cut;
      d_miss_nxt  = q_data.extra;
    end else if (d_done) begin
      d_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (o_load) begin
      out_valid_nxt = d_valid_r;
      out_nxt       = res;
    end

    empty    = !out_valid_r;
    out_data = out_r;
  end

  always_ff @(posedge clk) begin
    d_cp_r   <= d_cp_nxt;
    d_last_r <= d_last_nxt;
    d_cut_r  <= d_cut_nxt;
    d_miss_r <= d_miss_nxt;
    out_r    <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r   <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      d_valid_r   <= d_valid_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    d_valid_r |-> (idx_r < n_res))
    else $error("result index past the end of the command");

  a_term_final: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.kind == KIND_TERM || out_r.kind == KIND_CUT))
      |-> out_r.final_result)
    else $error("stop result is not the final one of its byte");

  a_idle_idx: assert property (@(posedge clk) disable iff (!rst_n)
    !d_valid_r |-> (idx_r == 2'd0))
    else $error("result index left over in an empty decode stage");

endmodule

// File: rtl/utf8_to_utf16_transcoder.sv
// UTF-8 to UTF-16 transcoder: top level joining front end, command queue and back end.
//
// Input channel: one UTF-8 byte per transfer in in_data, with last_byte marking the
// final byte of a source buffer. A byte transfers on a rising edge with push high
// and full low. Result channel: the oldest result sits on out_data while empty is
// low and transfers on a rising edge with pop high.
// The front end folds each byte into the open sequence and, when a sequence
// completes or the buffer ends, writes one command into a QUEUE_DEPTH-entry
// queue. The back end computes the code point and shifts out one to three
// results, one per cycle while the receiver pops, through its output register.
// The front end takes one byte per cycle while full is low; the back end moves
// one result per cycle while the receiver pops, so a byte that yields a surrogate
// pair plus an end marker occupies it for each of those results.
// full rises when the command queue is full, which happens when the back end falls
// behind: on a stalled receiver, or on bytes that each yield two or three results.
// The receiver may hold pop low as long as it likes.
// Reset clears the open sequence, the discard state, the queue and the output.
module utf8_to_utf16_transcoder #(
  parameter int QUEUE_DEPTH = utt_pkg::UTT_QDEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  utt_pkg::utt_in_t   in_data,
  output logic               empty,
  input  logic               pop,
  output utt_pkg::utt_out_t  out_data
);
  import utt_pkg::*;

  logic     accept;
  logic     cmd_valid;
  utt_cmd_t cmd;
  logic     q_full;
  logic     q_valid;
  logic     q_pop;
  utt_cmd_t q_data;

  assign full   = q_full;
  assign accept = push && !q_full;

  utt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_item   (in_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  utt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cmd_valid),
    .wr_data  (cmd),
    .full     (q_full),
    .rd_valid (q_valid),
    .rd_en    (q_pop),
    .rd_data  (q_data)
  );

  utt_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule
